// ===== rtl/efifs_pkg.sv =====
// efifs_pkg: constants for the extended float integer/fraction split
// no dependencies
package efifs_pkg;
	localparam int EXP_WIDTH_DEF  = 15;
	localparam int MANT_WIDTH_DEF = 64;
	localparam int EXP_BIAS_DEF   = 16383;
endpackage

// ===== rtl/efifs_if.sv =====
// efifs_if: valid/ready channel carrying a generic payload
// depends on nothing; payload width set by parameter
interface efifs_if #(
	parameter int W = 1
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/extended_float_integer_fraction_split.sv =====
// extended_float_integer_fraction_split: each accepted transaction is split and registered in the output register
// throughput one transaction per cycle while the output is ready; input register then output register
// arst_n clears the valid flags; payload registers are not reset
// depends on efifs_pkg, efifs_if, efifs_core
module extended_float_integer_fraction_split #(
	parameter int EXP_WIDTH  = efifs_pkg::EXP_WIDTH_DEF,
	parameter int MANT_WIDTH = efifs_pkg::MANT_WIDTH_DEF,
	parameter int EXP_BIAS   = efifs_pkg::EXP_BIAS_DEF
) (
	input logic clk,
	input logic arst_n,
	efifs_if.sink   in_ch,
	efifs_if.source out_ch
);
	import efifs_pkg::*;
	localparam int IW = 1 + EXP_WIDTH + MANT_WIDTH;
	localparam int OW = 2 * IW;

	logic          v_s1, v_s2;
	logic [IW-1:0] d_s1;
	logic [OW-1:0] d_s2, res;
	logic          adv1, adv2;

	// stage enables
	assign adv2        = !v_s2 || out_ch.ready;
	assign adv1        = !v_s1 || adv2;
	assign in_ch.ready = adv1;

	// split logic
	efifs_core #(.EXP_WIDTH(EXP_WIDTH), .MANT_WIDTH(MANT_WIDTH), .EXP_BIAS(EXP_BIAS)) u_core (
		.sign         (d_s1[IW-1]),
		.exponent     (d_s1[IW-2 -: EXP_WIDTH]),
		.mantissa     (d_s1[MANT_WIDTH-1:0]),
		.int_sign     (res[OW-1]),
		.int_exponent (res[OW-2 -: EXP_WIDTH]),
		.int_mantissa (res[IW+MANT_WIDTH-1 -: MANT_WIDTH]),
		.frac_sign    (res[IW-1]),
		.frac_exponent(res[IW-2 -: EXP_WIDTH]),
		.frac_mantissa(res[MANT_WIDTH-1:0])
	);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_ch.valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv1 && in_ch.valid) d_s1 <= in_ch.data[IW-1:0];
		if (adv2 && v_s1) d_s2 <= res;
	end

	assign out_ch.valid = v_s2;
	assign out_ch.data  = d_s2;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed while stalled");
	// ready when output is free
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input blocked with empty output");
	// accepted item reaches stage one
	a_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> v_s1)
		else $error("accepted transaction lost");
endmodule

// ===== rtl/efifs_core.sv =====
// efifs_core: combinational split of one operand into integer and fraction parts
// depends on efifs_pkg
module efifs_core #(
	parameter int EXP_WIDTH  = efifs_pkg::EXP_WIDTH_DEF,
	parameter int MANT_WIDTH = efifs_pkg::MANT_WIDTH_DEF,
	parameter int EXP_BIAS   = efifs_pkg::EXP_BIAS_DEF
) (
	input  logic                  sign,
	input  logic [EXP_WIDTH-1:0]  exponent,
	input  logic [MANT_WIDTH-1:0] mantissa,
	output logic                  int_sign,
	output logic [EXP_WIDTH-1:0]  int_exponent,
	output logic [MANT_WIDTH-1:0] int_mantissa,
	output logic                  frac_sign,
	output logic [EXP_WIDTH-1:0]  frac_exponent,
	output logic [MANT_WIDTH-1:0] frac_mantissa
);
	import efifs_pkg::*;
	localparam int SW = $clog2(MANT_WIDTH);
	localparam int EW = EXP_WIDTH + 2;
	localparam logic [EW-1:0] BIAS_E = EW'(EXP_BIAS);
	localparam logic [EW-1:0] TOP_E  = EW'(EXP_BIAS + MANT_WIDTH - 1);

	logic                  is_special, all_int, no_int;
	logic [SW-1:0]         nfrac, lz;
	logic [MANT_WIDTH-1:0] fmask, f;
	logic                  found;
	logic [EW-1:0]         exp_ext;

	// classify operand
	always_comb begin
		exp_ext    = EW'(exponent);
		is_special = &exponent;
		all_int    = exp_ext >= TOP_E;
		no_int     = exp_ext < BIAS_E;
		nfrac      = SW'(TOP_E - exp_ext);
		fmask      = (MANT_WIDTH'(1) << nfrac) - MANT_WIDTH'(1);
		f          = mantissa & fmask;
	end

	// leading zero count of fraction bits
	always_comb begin
		lz    = '0;
		found = 1'b0;
		for (int i = MANT_WIDTH - 1; i >= 0; i--) begin
			if (!found && f[i]) begin
				lz    = SW'(MANT_WIDTH - 1 - i);
				found = 1'b1;
			end
		end
	end

	// select results
	always_comb begin
		int_sign      = 1'b0;
		int_exponent  = '0;
		int_mantissa  = '0;
		frac_sign     = 1'b0;
		frac_exponent = '0;
		frac_mantissa = '0;
		if (is_special || all_int) begin
			int_sign     = sign;
			int_exponent = exponent;
			int_mantissa = mantissa;
		end else if (no_int) begin
			frac_sign     = sign;
			frac_exponent = exponent;
			frac_mantissa = mantissa;
		end else begin
			int_sign     = sign;
			int_exponent = exponent;
			int_mantissa = mantissa & ~fmask;
			if (found) begin
				frac_sign = sign;
				if (exp_ext > EW'(lz)) begin
					frac_exponent = EXP_WIDTH'(exp_ext - EW'(lz));
					frac_mantissa = f << lz;
				end else begin
					frac_exponent = '0;
					frac_mantissa = f << SW'(exp_ext - EW'(1));
				end
			end
		end
	end
endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for extended_float_integer_fraction_split
// depends on efifs_pkg, efifs_if and the block itself
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int EW = efifs_pkg::EXP_WIDTH_DEF;
	localparam int MW = efifs_pkg::MANT_WIDTH_DEF;
	localparam int BIAS = efifs_pkg::EXP_BIAS_DEF;
	localparam int IN_W = 1 + EW + MW;
	localparam int OUT_W = 2 * IN_W;
	localparam logic [EW-1:0] EXP_ALL_ONES = '1;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic          sign;
		logic [EW-1:0] expo;
		logic [MW-1:0] mant;
	} xfloat_t;

	typedef struct packed {
		xfloat_t ipart;
		xfloat_t fpart;
	} split_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int cycles = 0;
	int errors = 0;

	efifs_if #(.W(IN_W)) in_ch ();
	efifs_if #(.W(OUT_W)) out_ch ();

	extended_float_integer_fraction_split dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	split_t expected_splits[$];

	// clock
	always #6 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	// integer/fraction split of one operand
	function automatic split_t modf_split(xfloat_t x);
		split_t r;
		int e;
		int nfrac;
		int lead;
		int shift;
		logic [MW-1:0] fmask;
		logic [MW-1:0] f;
		r = '0;
		e = int'(x.expo) - BIAS;
		if (x.expo == EXP_ALL_ONES || e >= MW - 1) begin
			r.ipart = x;
		end else if (e < 0) begin
			r.fpart = x;
		end else begin
			nfrac = MW - 1 - e;
			fmask = (MW'(1) << nfrac) - MW'(1);
			f = x.mant & fmask;
			r.ipart = x;
			r.ipart.mant = x.mant & ~fmask;
			if (f != '0) begin
				lead = 0;
				for (int i = 0; i < MW; i++)
					if (f[i]) lead = i;
				shift = MW - 1 - lead;
				r.fpart.sign = x.sign;
				if (int'(x.expo) > shift) begin
					r.fpart.expo = x.expo - EW'(shift);
					r.fpart.mant = f << shift;
				end else begin
					r.fpart.expo = '0;
					r.fpart.mant = f << (int'(x.expo) - 1);
				end
			end
		end
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(5, 20);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("extended_float_integer_fraction_split verification failed");
			$finish;
		end
	end

	// sink side: random stalls
	int stall_left = 0;
	bit calm = 1'b0;
	always @(posedge clk) begin
		if (calm || stall_left == 0) begin
			out_ch.ready <= 1'b1;
			stall_left = calm ? 0 : gap_len();
		end else begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end
	end

	// check each result transaction against the oldest prediction
	always @(posedge clk) begin
		split_t got;
		split_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_splits.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_splits.pop_front();
				if (got.ipart.sign !== want.ipart.sign) begin
					$display("%0t: int_sign exp %h got %h", $time, want.ipart.sign,
						got.ipart.sign);
					errors++;
				end
				if (got.ipart.expo !== want.ipart.expo) begin
					$display("%0t: int_exponent exp %h got %h", $time, want.ipart.expo,
						got.ipart.expo);
					errors++;
				end
				if (got.ipart.mant !== want.ipart.mant) begin
					$display("%0t: int_mantissa exp %h got %h", $time, want.ipart.mant,
						got.ipart.mant);
					errors++;
				end
				if (got.fpart.sign !== want.fpart.sign) begin
					$display("%0t: frac_sign exp %h got %h", $time, want.fpart.sign,
						got.fpart.sign);
					errors++;
				end
				if (got.fpart.expo !== want.fpart.expo) begin
					$display("%0t: frac_exponent exp %h got %h", $time, want.fpart.expo,
						got.fpart.expo);
					errors++;
				end
				if (got.fpart.mant !== want.fpart.mant) begin
					$display("%0t: frac_mantissa exp %h got %h", $time, want.fpart.mant,
						got.fpart.mant);
					errors++;
				end
			end
		end
	end

	// send one operand; valid stays high across back-to-back transactions
	task automatic send_operand(xfloat_t x, bit allow_gap = 1'b1);
		int g;
		g = allow_gap ? gap_len() : 0;
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= x;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		expected_splits.push_back(modf_split(x));
	endtask

	task automatic go_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic xfloat_t mk(logic s, logic [EW-1:0] ex, logic [MW-1:0] m);
		xfloat_t x;
		x.sign = s;
		x.expo = ex;
		x.mant = m;
		return x;
	endfunction

	function automatic logic [MW-1:0] rand_mant();
		return {$urandom, $urandom};
	endfunction

	// extremes and special cases
	task automatic test_directed();
		send_operand(mk(1'b0, '0, '0));
		send_operand(mk(1'b1, '0, '0));
		send_operand(mk(1'b1, '0, 64'h1));
		send_operand(mk(1'b0, EXP_ALL_ONES, 64'h8000_0000_0000_0000));
		send_operand(mk(1'b1, EXP_ALL_ONES, '1));
		send_operand(mk(1'b0, EW'(EXP_ALL_ONES - 1), '1));
		send_operand(mk(1'b1, EW'(BIAS + MW - 1), '1));
		send_operand(mk(1'b0, EW'(BIAS + MW - 2), '1));
		send_operand(mk(1'b1, EW'(BIAS + MW - 2), 64'hFFFF_FFFF_FFFF_FFFE));
		send_operand(mk(1'b0, EW'(BIAS), 64'h8000_0000_0000_0000));
		send_operand(mk(1'b1, EW'(BIAS), 64'h8000_0000_0000_0001));
		send_operand(mk(1'b1, EW'(BIAS), 64'hC000_0000_0000_0000));
		send_operand(mk(1'b0, EW'(BIAS - 1), 64'hC000_0000_0000_0000));
		send_operand(mk(1'b1, EW'(BIAS + 3), 64'h0000_0000_0000_0001));
		send_operand(mk(1'b0, EW'(BIAS + 5), 64'h0F00_0000_0000_0000));
		send_operand(mk(1'b1, EW'(BIAS), '1));
		send_operand(mk(1'b0, EW'(BIAS + 10), 64'h5555_5555_5555_5555));
		send_operand(mk(1'b1, EW'(BIAS + 40), 64'hAAAA_AAAA_AAAA_AAAA));
		go_idle();
	endtask

	// random operands, mostly exponents in the split range
	task automatic test_random(int n);
		xfloat_t x;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			x.sign = 1'($urandom_range(0, 1));
			x.mant = rand_mant();
			if (k < 6) x.expo = EW'(BIAS + $urandom_range(0, MW - 2));
			else if (k == 6) x.expo = EXP_ALL_ONES;
			else if (k == 7) x.expo = EW'(BIAS - $urandom_range(1, 100));
			else x.expo = EW'($urandom);
			if ($urandom_range(0, 7) == 0) x.mant = x.mant >> $urandom_range(0, 63);
			send_operand(x);
		end
		go_idle();
	endtask

	// drain pause, then a burst at full rate with the sink always ready
	task automatic test_full_rate(int n);
		while (expected_splits.size() != 0) @(posedge clk);
		calm = 1'b1;
		for (int i = 0; i < n; i++)
			send_operand(mk(1'($urandom_range(0, 1)), EW'(BIAS + $urandom_range(0, MW)),
				rand_mant()), 1'b0);
		go_idle();
		calm = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		test_full_rate(60);
		test_random(200);
		while (expected_splits.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("extended_float_integer_fraction_split verification clean");
		else
			$display("extended_float_integer_fraction_split verification failed");
		$finish;
	end
endmodule
